// File: src/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, request encoding, datapath command encoding and status
// bundle for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

	localparam int RADIUS_BITS = 10;
	localparam int COORD_BITS  = 11;

	localparam int OUT_W  = COORD_BITS + 1;
	localparam int SQ_W   = 2 * RADIUS_BITS;
	localparam int TX_W   = RADIUS_BITS + 1;
	localparam int TX2_W  = 2 * RADIUS_BITS + 2;
	localparam int PROD_W = SQ_W + TX2_W;
	localparam int DX_W   = 3 * RADIUS_BITS + 6;
	localparam int DEC_W  = 4 * RADIUS_BITS + 8;

	// request kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_RXRX,
		MUL_RYRY,
		MUL_RX2RY,
		MUL_TXTX,
		MUL_YMYM,
		MUL_RY2TA,
		MUL_RX2TB,
		MUL_RX2RY2
	} mul_op_t;

	typedef enum logic [3:0] {
		WR_NONE,
		WR_RX2,
		WR_RY2,
		WR_START,
		WR_TMP_A,
		WR_TMP_B,
		WR_ACC,
		WR_ACC_ADD,
		WR_ACC_SUB
	} wr_op_t;

	typedef struct packed {
		logic    load;
		logic    step_a;
		logic    step_b;
		logic    emit;
		mul_op_t mul_op;
		wr_op_t  wr_op;
	} dp_cmd_t;

	typedef struct packed {
		logic y_zero;
		logic switch_req;
	} dp_status_t;

endpackage

// File: src/mer_dp.sv
// ----------------------------------------------------------------------------
// mer_dp
// Datapath: held center and radii, offsets, step terms, decision variable,
// one shared registered multiplier and the output payload register.
// ----------------------------------------------------------------------------
module mer_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mer_pkg::dp_cmd_t               cmd,
	output mer_pkg::dp_status_t            status,
	input  logic [mer_pkg::COORD_BITS-1:0]  center_x,
	input  logic [mer_pkg::COORD_BITS-1:0]  center_y,
	input  logic [mer_pkg::RADIUS_BITS-1:0] radius_x,
	input  logic [mer_pkg::RADIUS_BITS-1:0] radius_y,
	output logic [mer_pkg::OUT_W-1:0]        x_right,
	output logic signed [mer_pkg::OUT_W-1:0] x_left,
	output logic [mer_pkg::OUT_W-1:0]        y_below,
	output logic signed [mer_pkg::OUT_W-1:0] y_above,
	output logic                             last
);
	import mer_pkg::*;

	logic [COORD_BITS-1:0]  cx_q, cy_q;
	logic [RADIUS_BITS-1:0] rx_q, ry_q;
	logic [RADIUS_BITS-1:0] x_q, y_q;
	logic [SQ_W-1:0]        rx2_q, ry2_q;
	logic [DX_W-1:0]        dx_q, dy_q;
	logic [DEC_W-1:0]       dec_q;
	logic [TX2_W-1:0]       tmp_a_q;
	logic [SQ_W-1:0]        tmp_b_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   region_two_q;
	logic                   use_dx_q, use_dy_q;

	logic [OUT_W-1:0]        x_right_q, y_below_q;
	logic signed [OUT_W-1:0] x_left_q, y_above_q;
	logic                    last_q;

	logic [SQ_W-1:0]        mul_a;
	logic [TX2_W-1:0]       mul_b;
	logic [TX_W-1:0]        tx;
	logic [RADIUS_BITS-1:0] ym_abs;
	logic                   neg, pos, incr_x, decr_y;
	logic [DEC_W-1:0]       term;

	assign tx     = {x_q, 1'b1};
	assign ym_abs = (y_q == '0) ? RADIUS_BITS'(1) : y_q - RADIUS_BITS'(1);

	always_comb begin
		unique case (cmd.mul_op)
			MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			MUL_RXRX: begin
				mul_a = SQ_W'(rx_q);
				mul_b = TX2_W'(rx_q);
			end
			MUL_RYRY: begin
				mul_a = SQ_W'(ry_q);
				mul_b = TX2_W'(ry_q);
			end
			MUL_RX2RY: begin
				mul_a = rx2_q;
				mul_b = TX2_W'(ry_q);
			end
			MUL_TXTX: begin
				mul_a = SQ_W'(tx);
				mul_b = TX2_W'(tx);
			end
			MUL_YMYM: begin
				mul_a = SQ_W'(ym_abs);
				mul_b = TX2_W'(ym_abs);
			end
			MUL_RY2TA: begin
				mul_a = ry2_q;
				mul_b = tmp_a_q;
			end
			MUL_RX2TB: begin
				mul_a = rx2_q;
				mul_b = TX2_W'(tmp_b_q);
			end
			MUL_RX2RY2: begin
				mul_a = rx2_q;
				mul_b = TX2_W'(ry2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// step decision flags
	assign neg    = dec_q[DEC_W-1];
	assign pos    = !neg && (dec_q != '0);
	assign incr_x = !region_two_q || !pos;
	assign decr_y = region_two_q || !neg;

	assign term = (use_dx_q ? DEC_W'(dx_q) : '0)
	            - (use_dy_q ? DEC_W'(dy_q) : '0)
	            + (region_two_q ? DEC_W'(rx2_q) : DEC_W'(ry2_q));

	assign status.y_zero     = (y_q == '0);
	assign status.switch_req = !region_two_q && !(dx_q < dy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_two_q <= 1'b0;
		end else if (cmd.load) begin
			region_two_q <= 1'b0;
		end else if (cmd.wr_op == WR_ACC_SUB) begin
			region_two_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);

		if (cmd.load) begin
			cx_q <= center_x;
			cy_q <= center_y;
			rx_q <= radius_x;
			ry_q <= radius_y;
			x_q  <= '0;
			y_q  <= radius_y;
			dx_q <= '0;
		end

		if (cmd.step_a) begin
			use_dx_q <= incr_x;
			use_dy_q <= decr_y;
			if (incr_x) begin
				x_q  <= x_q + RADIUS_BITS'(1);
				dx_q <= dx_q + (DX_W'(ry2_q) << 1);
			end
			if (decr_y) begin
				y_q  <= y_q - RADIUS_BITS'(1);
				dy_q <= dy_q - (DX_W'(rx2_q) << 1);
			end
		end

		if (cmd.step_b) begin
			dec_q <= dec_q + (term << 2);
		end

		unique case (cmd.wr_op)
			WR_NONE: begin
			end
			WR_RX2: begin
				rx2_q <= SQ_W'(prod_q);
			end
			WR_RY2: begin
				ry2_q <= SQ_W'(prod_q);
			end
			WR_START: begin
				dy_q  <= DX_W'(prod_q) << 1;
				dec_q <= (DEC_W'(ry2_q) << 2) - (DEC_W'(prod_q) << 2) + DEC_W'(rx2_q);
			end
			WR_TMP_A: begin
				tmp_a_q <= TX2_W'(prod_q);
			end
			WR_TMP_B: begin
				tmp_b_q <= SQ_W'(prod_q);
			end
			WR_ACC: begin
				dec_q <= DEC_W'(prod_q);
			end
			WR_ACC_ADD: begin
				dec_q <= dec_q + (DEC_W'(prod_q) << 2);
			end
			WR_ACC_SUB: begin
				dec_q <= dec_q - (DEC_W'(prod_q) << 2);
			end
			default: begin
			end
		endcase

		if (cmd.emit) begin
			x_right_q <= OUT_W'(cx_q) + OUT_W'(x_q);
			x_left_q  <= OUT_W'(cx_q) - OUT_W'(x_q);
			y_below_q <= OUT_W'(cy_q) + OUT_W'(y_q);
			y_above_q <= OUT_W'(cy_q) - OUT_W'(y_q);
			last_q    <= (y_q == '0);
		end
	end

	assign x_right = x_right_q;
	assign x_left  = x_left_q;
	assign y_below = y_below_q;
	assign y_above = y_above_q;
	assign last    = last_q;

endmodule

// File: src/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl
// Controller: request handshake, start and region-switch multiply sequences,
// step phases, output valid and the active flag.
// ----------------------------------------------------------------------------
module mer_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mer_pkg::dp_status_t  status,
	output mer_pkg::dp_cmd_t     cmd
);
	import mer_pkg::*;

	typedef enum logic [3:0] {
		S_WAIT,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_STEP_B,
		S_INIT0,
		S_INIT1,
		S_INIT2,
		S_INIT3,
		S_INIT4,
		S_INIT5,
		S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, active_q;
	logic   slot_free, accept;

	assign in_ready  = (state_q == S_WAIT);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_WAIT: begin
				if (accept && req_type == REQ_START) begin
					cmd.load = 1'b1;
					state_d  = S_M1;
				end else if (accept && active_q) begin
					cmd.step_a = 1'b1;
					state_d    = S_STEP_B;
				end
			end
			S_M1: begin
				cmd.mul_op = MUL_RXRX;
				state_d    = S_M2;
			end
			S_M2: begin
				cmd.mul_op = MUL_RYRY;
				cmd.wr_op  = WR_RX2;
				state_d    = S_M3;
			end
			S_M3: begin
				cmd.mul_op = MUL_RX2RY;
				cmd.wr_op  = WR_RY2;
				state_d    = S_M4;
			end
			S_M4: begin
				cmd.wr_op = WR_START;
				state_d   = S_EMIT;
			end
			S_STEP_B: begin
				cmd.step_b = 1'b1;
				if (status.switch_req) begin
					state_d = S_INIT0;
				end else if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_WAIT;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_INIT0: begin
				cmd.mul_op = MUL_TXTX;
				state_d    = S_INIT1;
			end
			S_INIT1: begin
				cmd.mul_op = MUL_YMYM;
				cmd.wr_op  = WR_TMP_A;
				state_d    = S_INIT2;
			end
			S_INIT2: begin
				cmd.mul_op = MUL_RY2TA;
				cmd.wr_op  = WR_TMP_B;
				state_d    = S_INIT3;
			end
			S_INIT3: begin
				cmd.mul_op = MUL_RX2TB;
				cmd.wr_op  = WR_ACC;
				state_d    = S_INIT4;
			end
			S_INIT4: begin
				cmd.mul_op = MUL_RX2RY2;
				cmd.wr_op  = WR_ACC_ADD;
				state_d    = S_INIT5;
			end
			S_INIT5: begin
				cmd.wr_op = WR_ACC_SUB;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_WAIT;
				end
			end
			default: begin
				state_d = S_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WAIT;
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				active_q <= 1'b1;
			end else if (cmd.emit) begin
				active_q <= !status.y_zero;
			end
		end
	end

endmodule

// File: src/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse rasterizer: start requests latch center and radii and emit
// the top point, step requests walk the first quadrant one point at a time.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    req_type, center_x, center_y, radius_x, radius_y
//   out      out_valid/out_ready  x_right, x_left, y_below, y_above, last
//
// a step request applies its step and registers its point; a step that crosses
// into region two adds the five products of the shared multiplier
// a start request reaches its point after three squaring and product steps
// through the same multiplier
// a step request while idle is taken and gives no point
// the output register lets the next request in while a point waits; a stalled
// output holds the controller in its emit state
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [mer_pkg::COORD_BITS-1:0]  center_x,
	input  logic [mer_pkg::COORD_BITS-1:0]  center_y,
	input  logic [mer_pkg::RADIUS_BITS-1:0] radius_x,
	input  logic [mer_pkg::RADIUS_BITS-1:0] radius_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mer_pkg::OUT_W-1:0]        x_right,
	output logic signed [mer_pkg::OUT_W-1:0] x_left,
	output logic [mer_pkg::OUT_W-1:0]        y_below,
	output logic signed [mer_pkg::OUT_W-1:0] y_above,
	output logic                             last
);
	import mer_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mer_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.center_x (center_x),
		.center_y (center_y),
		.radius_x (radius_x),
		.radius_y (radius_y),
		.x_right  (x_right),
		.x_left   (x_left),
		.y_below  (y_below),
		.y_above  (y_above),
		.last     (last)
	);

endmodule
